// ----- src/stt_pkg.sv -----
// package: types, codes and byte classification for the source text tokenizer
package stt_pkg;

  localparam int POS_BITS_DEF    = 16;
  localparam int KEYWORD_MAX_DEF = 5;
  localparam int OQ_DEPTH        = 4;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NUM,
    MODE_IDENT,
    MODE_STR
  } scan_mode_t;

  typedef enum logic [4:0] {
    TOK_END    = 5'd0,
    TOK_INT    = 5'd1,
    TOK_IDENT  = 5'd2,
    TOK_STRING = 5'd3,
    TOK_IF     = 5'd4,
    TOK_ELSE   = 5'd5,
    TOK_WHILE  = 5'd6,
    TOK_RP     = 5'd7,
    TOK_LT     = 5'd8,
    TOK_EQ     = 5'd9,
    TOK_PLUS   = 5'd10,
    TOK_MINUS  = 5'd11,
    TOK_STAR   = 5'd12,
    TOK_SLASH  = 5'd13,
    TOK_LBRACE = 5'd14,
    TOK_RBRACE = 5'd15,
    TOK_LPAREN = 5'd16,
    TOK_RPAREN = 5'd17,
    TOK_BAD    = 5'd18,
    TOK_UNTERM = 5'd19
  } tok_type_t;

  localparam logic [15:0] BAD_MSG_LEN    = 16'd23;
  localparam logic [15:0] UNTERM_MSG_LEN = 16'd19;
  localparam logic [15:0] LEN_MAX        = 16'hFFFF;

  localparam logic [39:0] KW_IF    = 40'h6966;
  localparam logic [39:0] KW_ELSE  = 40'h656C7365;
  localparam logic [39:0] KW_WHILE = 40'h7768696C65;
  localparam logic [39:0] KW_RP    = 40'h7270;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    tok_type_t   token_type;
    logic [15:0] token_length;
    logic [7:0]  bad_char;
    logic [15:0] end_line;
    logic [15:0] end_column;
    logic        last_of_run;
  } tok_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c inside {8'h20, [8'h09:8'h0D]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  endfunction

  function automatic tok_type_t op_type(input logic [7:0] c);
    case (c)
      8'h3C:   op_type = TOK_LT;
      8'h3D:   op_type = TOK_EQ;
      8'h2B:   op_type = TOK_PLUS;
      8'h2D:   op_type = TOK_MINUS;
      8'h2A:   op_type = TOK_STAR;
      8'h2F:   op_type = TOK_SLASH;
      8'h7B:   op_type = TOK_LBRACE;
      8'h7D:   op_type = TOK_RBRACE;
      8'h28:   op_type = TOK_LPAREN;
      8'h29:   op_type = TOK_RPAREN;
      default: op_type = TOK_BAD;
    endcase
  endfunction

endpackage

// ----- src/source_text_tokenizer.sv -----
// top level: streaming lexical tokenizer with scan state and result queue
//
//  channel  direction  fields                                              handshake
//  in_      input      kind, char_byte                                     in_valid / in_stall
//  out_     output     token_type, token_length, bad_char, end_line,      out_valid / out_stall
//                      end_column, last_of_run
//
//  one byte per cycle while in_stall is low: scan state and counters update in the cycle a transaction is taken
//  each byte yields zero, one or two tokens, written into a four-entry result queue
//  in_stall rises while the queue has fewer than two free entries
//  results leave the queue one per cycle while out_stall is low, first token of a byte first
//  rst_n (synchronous) returns the scanner to idle at line 1, column 1 and empties the queue
module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int POS_BITS    = POS_BITS_DEF,
  parameter int KEYWORD_MAX = KEYWORD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_type,
  output logic [15:0] out_token_length,
  output logic [7:0]  out_bad_char,
  output logic [15:0] out_end_line,
  output logic [15:0] out_end_column,
  output logic        out_last_of_run
);

  localparam int PRE_W = 8 * KEYWORD_MAX;
  localparam int PW    = (POS_BITS > 16) ? POS_BITS : 16;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    sat16 = (w > PW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  scan_mode_t          mode_r, mode_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt, col_r, col_nxt, mv_line, mv_col;
  logic [15:0]         len_r, len_nxt, len_grow;
  logic [PRE_W-1:0]    pre_r, pre_nxt;

  tok_t                queue_r [OQ_DEPTH];
  logic [1:0]          wptr_r, rptr_r;
  logic [2:0]          cnt_r;

  logic                in_acc, out_acc;
  logic [7:0]          c;
  logic                c_space, c_digit, c_word;

  scan_mode_t          ib_mode;
  logic [15:0]         ib_len, ib_tlen;
  logic [PRE_W-1:0]    ib_pre;
  logic                ib_emit;
  tok_type_t           ib_type;
  logic [7:0]          ib_bad;
  tok_type_t           word_ty;

  logic                a_v, b_v, b_next;
  tok_type_t           a_type, b_type;
  logic [15:0]         a_len, b_len;
  logic [7:0]          b_bad;
  tok_t                tok_a, tok_b, push0, push1;
  logic [1:0]          push_n;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (cnt_r > 3'd2);
  assign c        = in_char_byte;
  assign c_space  = is_space(c);
  assign c_digit  = is_digit(c);
  assign c_word   = is_alpha(c) || c_digit || (c == CH_UNDER);
  assign len_grow = (len_r < LEN_MAX) ? len_r + 16'd1 : len_r;

  // position after the current byte
  always_comb begin
    mv_line = line_r;
    mv_col  = col_r;
    if (c == CH_NL) begin
      if (line_r < POS_MAX) mv_line = line_r + POS_ONE;
      mv_col = POS_ONE;
    end else if (col_r < POS_MAX) begin
      mv_col = col_r + POS_ONE;
    end
  end

  // keyword match on the identifier being collected
  always_comb begin
    word_ty = TOK_IDENT;
    if (len_r <= 16'(KEYWORD_MAX)) begin
      if (len_r == 16'd2 && pre_r == PRE_W'(KW_IF)) word_ty = TOK_IF;
      else if (len_r == 16'd4 && pre_r == PRE_W'(KW_ELSE)) word_ty = TOK_ELSE;
      else if (len_r == 16'd5 && pre_r == PRE_W'(KW_WHILE)) word_ty = TOK_WHILE;
      else if (len_r == 16'd2 && pre_r == PRE_W'(KW_RP)) word_ty = TOK_RP;
    end
  end

  // byte seen between tokens
  always_comb begin
    ib_mode = MODE_IDLE;
    ib_len  = len_r;
    ib_pre  = pre_r;
    ib_emit = 1'b0;
    ib_type = op_type(c);
    ib_tlen = 16'd1;
    ib_bad  = 8'd0;
    if (c_space) begin
      ib_mode = MODE_IDLE;
    end else if (c == CH_HASH) begin
      ib_mode = MODE_COMMENT;
    end else if (c_digit) begin
      ib_mode = MODE_NUM;
      ib_len  = 16'd1;
    end else if (c_word) begin
      ib_mode = MODE_IDENT;
      ib_len  = 16'd1;
      ib_pre  = PRE_W'(c);
    end else if (c == CH_QUOTE) begin
      ib_mode = MODE_STR;
      ib_len  = 16'd0;
    end else begin
      ib_emit = 1'b1;
      if (ib_type == TOK_BAD) begin
        ib_tlen = BAD_MSG_LEN;
        ib_bad  = c;
      end
    end
  end

  // next scan mode
  always_comb begin
    mode_nxt = mode_r;
    if (in_acc) begin
      if (in_kind) begin
        mode_nxt = MODE_IDLE;
      end else begin
        case (mode_r)
          MODE_COMMENT: if (c == CH_NL || c == CH_NUL) mode_nxt = ib_mode;
          MODE_NUM:     if (!c_digit) mode_nxt = ib_mode;
          MODE_IDENT:   if (!c_word) mode_nxt = ib_mode;
          MODE_STR: begin
            if (c == CH_QUOTE) mode_nxt = MODE_IDLE;
            else if (c == CH_NUL) mode_nxt = ib_mode;
          end
          default:      mode_nxt = ib_mode;
        endcase
      end
    end
  end

  // counters, collected text and emitted tokens
  always_comb begin
    len_nxt  = len_r;
    pre_nxt  = pre_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    a_v      = 1'b0;
    a_type   = TOK_INT;
    a_len    = len_r;
    b_v      = 1'b0;
    b_type   = ib_type;
    b_len    = ib_tlen;
    b_bad    = ib_bad;
    b_next   = 1'b1;
    if (in_acc) begin
      if (in_kind) begin
        a_v = (mode_r == MODE_NUM) || (mode_r == MODE_IDENT) || (mode_r == MODE_STR);
        case (mode_r)
          MODE_NUM:   a_type = TOK_INT;
          MODE_IDENT: a_type = word_ty;
          default:    a_type = TOK_UNTERM;
        endcase
        if (mode_r == MODE_STR) a_len = UNTERM_MSG_LEN;
        b_v      = 1'b1;
        b_type   = TOK_END;
        b_len    = 16'd0;
        b_bad    = 8'd0;
        b_next   = 1'b0;
        len_nxt  = 16'd0;
        pre_nxt  = '0;
        line_nxt = POS_ONE;
        col_nxt  = POS_ONE;
      end else begin
        line_nxt = mv_line;
        col_nxt  = mv_col;
        case (mode_r)
          MODE_COMMENT: begin
            if (c == CH_NL || c == CH_NUL) begin
              len_nxt = ib_len;
              pre_nxt = ib_pre;
              b_v     = ib_emit;
            end
          end
          MODE_NUM: begin
            if (c_digit) begin
              len_nxt = len_grow;
            end else begin
              a_v     = 1'b1;
              a_type  = TOK_INT;
              len_nxt = ib_len;
              pre_nxt = ib_pre;
              b_v     = ib_emit;
            end
          end
          MODE_IDENT: begin
            if (c_word) begin
              if (len_r < 16'(KEYWORD_MAX)) pre_nxt = {pre_r[PRE_W-9:0], c};
              len_nxt = len_grow;
            end else begin
              a_v     = 1'b1;
              a_type  = word_ty;
              len_nxt = ib_len;
              pre_nxt = ib_pre;
              b_v     = ib_emit;
            end
          end
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              b_v    = 1'b1;
              b_type = TOK_STRING;
              b_len  = len_r;
              b_bad  = 8'd0;
            end else if (c == CH_NUL) begin
              a_v     = 1'b1;
              a_type  = TOK_UNTERM;
              a_len   = UNTERM_MSG_LEN;
              len_nxt = ib_len;
              pre_nxt = ib_pre;
              b_v     = ib_emit;
            end else begin
              len_nxt = len_grow;
            end
          end
          default: begin
            len_nxt = ib_len;
            pre_nxt = ib_pre;
            b_v     = ib_emit;
          end
        endcase
      end
    end
  end

  // pack tokens for the queue
  always_comb begin
    tok_a.token_type   = a_type;
    tok_a.token_length = a_len;
    tok_a.bad_char     = 8'd0;
    tok_a.end_line     = sat16(line_r);
    tok_a.end_column   = sat16(col_r);
    tok_a.last_of_run  = !b_v;
    tok_b.token_type   = b_type;
    tok_b.token_length = b_len;
    tok_b.bad_char     = b_bad;
    tok_b.end_line     = b_next ? sat16(mv_line) : sat16(line_r);
    tok_b.end_column   = b_next ? sat16(mv_col) : sat16(col_r);
    tok_b.last_of_run  = 1'b1;
    push0              = a_v ? tok_a : tok_b;
    push1              = tok_b;
    push_n             = {1'b0, a_v} + {1'b0, b_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      line_r <= POS_ONE;
      col_r  <= POS_ONE;
      len_r  <= 16'd0;
      pre_r  <= '0;
      wptr_r <= 2'd0;
      rptr_r <= 2'd0;
      cnt_r  <= 3'd0;
    end else begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      len_r  <= len_nxt;
      pre_r  <= pre_nxt;
      wptr_r <= wptr_r + push_n;
      rptr_r <= rptr_r + {1'b0, out_acc};
      cnt_r  <= cnt_r + {1'b0, push_n} - {2'b00, out_acc};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) queue_r[wptr_r] <= push0;
    if (push_n == 2'd2) queue_r[wptr_r + 2'd1] <= push1;
  end

  assign out_valid        = (cnt_r != 3'd0);
  assign out_token_type   = queue_r[rptr_r].token_type;
  assign out_token_length = queue_r[rptr_r].token_length;
  assign out_bad_char     = queue_r[rptr_r].bad_char;
  assign out_end_line     = queue_r[rptr_r].end_line;
  assign out_end_column   = queue_r[rptr_r].end_column;
  assign out_last_of_run  = queue_r[rptr_r].last_of_run;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(OQ_DEPTH))
    else $error("result queue overflow");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind) |=> (mode_r == MODE_IDLE && line_r == POS_ONE && col_r == POS_ONE))
    else $error("scanner not back to start after end marker");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_type == TOK_END) |-> out_last_of_run)
    else $error("end token not marked last");

  a_bad_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_type != TOK_BAD) |-> (out_bad_char == 8'd0))
    else $error("offending byte on a non-error token");

endmodule
